/* rtl/core/wlru_pkg.sv */
// ----------------------------------------------------------------------------
// wlru_pkg
// Shared types and constants for the weighted LRU victim select block:
// operation codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package wlru_pkg;

    // Fixed widths of the transaction fields
    localparam int STAMP_BITS  = 48;
    localparam int FUNC_BITS   = 3;
    localparam int SET_BITS    = 8;
    localparam int WAY_BITS    = 4;
    localparam int WT_IN_BITS  = 8;

    // Operation codes
    typedef enum logic [FUNC_BITS-1:0] {
        FN_TOUCH        = 3'd0,
        FN_TOUCH_WEIGHT = 3'd1,
        FN_RESET        = 3'd2,
        FN_INVALIDATE   = 3'd3,
        FN_FIND         = 3'd4
    } t_func;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage : wlru_pkg

`default_nettype wire

/* rtl/core/wlru_ram.sv */
// ----------------------------------------------------------------------------
// wlru_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : wlru_ram

`default_nettype wire

/* rtl/core/wlru_cmp.sv */
// ----------------------------------------------------------------------------
// wlru_cmp
// Shared victim compare unit: flags a candidate way that beats the current
// best, ordering by weight first and last-use stamp second.
// ----------------------------------------------------------------------------
`default_nettype none

module wlru_cmp #(
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic [WEIGHT_BITS-1:0]          i_cand_weight,
    input  wire logic [wlru_pkg::STAMP_BITS-1:0] i_cand_stamp,
    input  wire logic [WEIGHT_BITS-1:0]          i_best_weight,
    input  wire logic [wlru_pkg::STAMP_BITS-1:0] i_best_stamp,
    output logic                                 o_less
);

    logic [WEIGHT_BITS+wlru_pkg::STAMP_BITS-1:0] cand_key;
    logic [WEIGHT_BITS+wlru_pkg::STAMP_BITS-1:0] best_key;

    // Strictly smaller key wins, so equal keys keep the lower way
    assign cand_key = {i_cand_weight, i_cand_stamp};
    assign best_key = {i_best_weight, i_best_stamp};
    assign o_less   = (cand_key < best_key);

endmodule : wlru_cmp

`default_nettype wire

/* rtl/core/weighted_lru_victim_select.sv */
// Transactions: an in-range touch, touch with weight, reset or invalidate holds busy for
// the RAM write in ST_WRITE; out-of-range writes and unused codes leave busy low. Find
// victim holds busy through ST_SCAN, one RAM read per way through the shared compare
// unit, and then ST_FLUSH, while the last read data returns; the result strobes in the next
// cycle, when busy is low again and a new transaction can be taken.
// Reset (sync, active low): clearing pass over all SETS*WAYS entries, busy throughout.
// ----------------------------------------------------------------------------
// weighted_lru_victim_select
// Per-way last-use stamps and weights in RAM; find victim scans the ways of a
// set one per cycle and returns the way of smallest weight, then oldest stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_lru_victim_select #(
    parameter int SETS        = 256,
    parameter int WAYS        = 16,
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [wlru_pkg::FUNC_BITS-1:0]  i_func,
    input  wire logic [wlru_pkg::SET_BITS-1:0]   i_set_index,
    input  wire logic [wlru_pkg::WAY_BITS-1:0]   i_way,
    input  wire logic [wlru_pkg::WT_IN_BITS-1:0] i_weight,
    output logic                             o_valid,
    output logic [wlru_pkg::WAY_BITS-1:0]    o_victim_way
);

    localparam int DEPTH = SETS * WAYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(WAYS);
    localparam int SB    = wlru_pkg::STAMP_BITS;

    // Registers
    wlru_pkg::t_state       r_state, n_state;
    logic [SB-1:0]          r_time, n_time;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic [AW-1:0]          r_base, n_base;
    logic [AW-1:0]          r_wr_addr, n_wr_addr;
    logic [SB-1:0]          r_wr_stamp, n_wr_stamp;
    logic [WEIGHT_BITS-1:0] r_wr_weight, n_wr_weight;
    logic                   r_wr_weight_en, n_wr_weight_en;
    logic [WW-1:0]          r_cnt, n_cnt;
    logic                   r_rd_vld, n_rd_vld;
    logic [WW-1:0]          r_rd_way, n_rd_way;
    logic [WEIGHT_BITS-1:0] r_best_weight, n_best_weight;
    logic [SB-1:0]          r_best_stamp, n_best_stamp;
    logic [WW-1:0]          r_best_way, n_best_way;
    logic                   r_out_valid, n_out_valid;
    logic [wlru_pkg::WAY_BITS-1:0] r_victim, n_victim;

    // RAM ports
    logic                   stamp_we;
    logic                   weight_we;
    logic [AW-1:0]          ram_waddr;
    logic [SB-1:0]          stamp_wdata;
    logic [WEIGHT_BITS-1:0] weight_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [SB-1:0]          stamp_rdata;
    logic [WEIGHT_BITS-1:0] weight_rdata;

    // Decode helpers
    logic                   accept;
    logic                   set_ok;
    logic                   way_ok;
    logic [31:0]            wt_wide;
    logic [WEIGHT_BITS-1:0] wt_in;
    logic                   cand_less;
    logic                   take_cand;
    logic [WW-1:0]          final_way;
    logic [WW+3:0]          final_wide;

    assign accept  = start && !busy;
    assign set_ok  = (32'(i_set_index) < SETS);
    assign way_ok  = (32'(i_way) < WAYS);
    assign wt_wide = {24'd0, i_weight};
    assign wt_in   = wt_wide[WEIGHT_BITS-1:0];

    // Shared compare unit
    wlru_cmp #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_cmp (
        .i_cand_weight (weight_rdata),
        .i_cand_stamp  (stamp_rdata),
        .i_best_weight (r_best_weight),
        .i_best_stamp  (r_best_stamp),
        .o_less        (cand_less)
    );

    // Stamp and weight stores
    wlru_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (ram_waddr),
        .i_wdata (stamp_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (stamp_rdata)
    );

    wlru_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (weight_we),
        .i_waddr (ram_waddr),
        .i_wdata (weight_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (weight_rdata)
    );

    // Drive RAM ports from the sequencer
    always_comb begin
        stamp_we     = 1'b0;
        weight_we    = 1'b0;
        ram_waddr    = r_wr_addr;
        stamp_wdata  = r_wr_stamp;
        weight_wdata = r_wr_weight;
        if (r_state == wlru_pkg::ST_CLEAR) begin
            stamp_we     = 1'b1;
            weight_we    = 1'b1;
            ram_waddr    = r_clr_addr;
            stamp_wdata  = '0;
            weight_wdata = '0;
        end else if (r_state == wlru_pkg::ST_WRITE) begin
            stamp_we  = 1'b1;
            weight_we = r_wr_weight_en;
        end
    end

    assign ram_raddr = r_base + AW'(r_cnt);

    // Pick the running best from the returning read data
    assign take_cand  = r_rd_vld && ((r_rd_way == '0) || cand_less);
    assign final_way  = take_cand ? r_rd_way : r_best_way;
    assign final_wide = {4'd0, final_way};

    // Next state and datapath
    always_comb begin
        n_state        = r_state;
        n_time         = r_time;
        n_clr_addr     = r_clr_addr;
        n_base         = r_base;
        n_wr_addr      = r_wr_addr;
        n_wr_stamp     = r_wr_stamp;
        n_wr_weight    = r_wr_weight;
        n_wr_weight_en = r_wr_weight_en;
        n_cnt          = r_cnt;
        n_rd_vld       = 1'b0;
        n_rd_way       = r_cnt;
        n_best_weight  = r_best_weight;
        n_best_stamp   = r_best_stamp;
        n_best_way     = r_best_way;
        n_out_valid    = 1'b0;
        n_victim       = r_victim;
        busy           = (r_state != wlru_pkg::ST_IDLE);

        // Fold in the way whose data returns this cycle
        if (take_cand) begin
            n_best_weight = weight_rdata;
            n_best_stamp  = stamp_rdata;
            n_best_way    = r_rd_way;
        end
        if (r_rd_vld && (r_rd_way == WW'(WAYS - 1))) begin
            n_out_valid = 1'b1;
            n_victim    = final_wide[wlru_pkg::WAY_BITS-1:0];
        end

        unique case (r_state)
            wlru_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = wlru_pkg::ST_IDLE;
                end
            end
            wlru_pkg::ST_IDLE: begin
                if (accept) begin
                    // Advance time once per transaction, saturating
                    if (r_time != '1) begin
                        n_time = r_time + SB'(1);
                    end
                    n_base         = AW'(32'(i_set_index) * WAYS);
                    n_wr_addr      = AW'(32'(i_set_index) * WAYS + 32'(i_way));
                    n_wr_stamp     = r_time;
                    n_wr_weight    = wt_in;
                    n_wr_weight_en = 1'b0;
                    n_cnt          = '0;
                    unique case (wlru_pkg::t_func'(i_func))
                        wlru_pkg::FN_TOUCH, wlru_pkg::FN_RESET: begin
                            if (set_ok && way_ok) begin
                                n_state = wlru_pkg::ST_WRITE;
                            end
                        end
                        wlru_pkg::FN_TOUCH_WEIGHT: begin
                            n_wr_weight_en = 1'b1;
                            if (set_ok && way_ok) begin
                                n_state = wlru_pkg::ST_WRITE;
                            end
                        end
                        wlru_pkg::FN_INVALIDATE: begin
                            n_wr_stamp = '0;
                            if (set_ok && way_ok) begin
                                n_state = wlru_pkg::ST_WRITE;
                            end
                        end
                        wlru_pkg::FN_FIND: begin
                            if (set_ok) begin
                                n_state = wlru_pkg::ST_SCAN;
                            end else begin
                                n_out_valid = 1'b1;
                                n_victim    = '0;
                            end
                        end
                        default: begin
                            // Unused code: time advance only
                        end
                    endcase
                end
            end
            wlru_pkg::ST_WRITE: begin
                n_state = wlru_pkg::ST_IDLE;
            end
            wlru_pkg::ST_SCAN: begin
                // Issue one way read per cycle
                n_rd_vld = 1'b1;
                n_cnt    = r_cnt + WW'(1);
                if (r_cnt == WW'(WAYS - 1)) begin
                    n_cnt   = '0;
                    n_state = wlru_pkg::ST_FLUSH;
                end
            end
            wlru_pkg::ST_FLUSH: begin
                // Last read data lands this cycle
                n_state = wlru_pkg::ST_IDLE;
            end
            default: begin
                n_state = wlru_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wlru_pkg::ST_CLEAR;
            r_time      <= SB'(1);
            r_clr_addr  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_clr_addr  <= n_clr_addr;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_base         <= n_base;
        r_wr_addr      <= n_wr_addr;
        r_wr_stamp     <= n_wr_stamp;
        r_wr_weight    <= n_wr_weight;
        r_wr_weight_en <= n_wr_weight_en;
        r_cnt          <= n_cnt;
        r_rd_way       <= n_rd_way;
        r_best_weight  <= n_best_weight;
        r_best_stamp   <= n_best_stamp;
        r_best_way     <= n_best_way;
        r_victim       <= n_victim;
    end

    assign o_valid      = r_out_valid;
    assign o_victim_way = r_victim;

endmodule : weighted_lru_victim_select

`default_nettype wire

/* rtl/core/wlru_checker.sv */
// ----------------------------------------------------------------------------
// wlru_checker
// Port-level checks on the victim select block: clearing pass after reset,
// results only after find transactions, and the out-of-range set result.
// ----------------------------------------------------------------------------
`default_nettype none

module wlru_checker #(
    parameter int SETS = 256
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [wlru_pkg::FUNC_BITS-1:0]    i_func,
    input wire logic [wlru_pkg::SET_BITS-1:0]     i_set_index,
    input wire logic                              o_valid,
    input wire logic [wlru_pkg::WAY_BITS-1:0]     o_victim_way
);

    logic acc_find;
    assign acc_find = start && !busy && (i_func == wlru_pkg::FN_FIND);

    // Reset starts the clearing pass with no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_valid))
        else $error("no clearing pass after reset");

    // A transaction other than find never yields a result
    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func != wlru_pkg::FN_FIND)) |=> !o_valid)
        else $error("result after a non-find transaction");

    // Find on a set out of range answers way zero without a scan
    a_bad_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_find && (32'(i_set_index) >= SETS)) |=>
            (o_valid && (o_victim_way == '0)))
        else $error("out-of-range find did not return way zero");

    // Find on a valid set occupies the block for the scan
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_find && (32'(i_set_index) < SETS)) |=> (busy && !o_valid))
        else $error("scan did not hold busy");

    // Results appear only once the block is free again
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

endmodule : wlru_checker

bind weighted_lru_victim_select wlru_checker #(
    .SETS (SETS)
) u_wlru_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_func       (i_func),
    .i_set_index  (i_set_index),
    .o_valid      (o_valid),
    .o_victim_way (o_victim_way)
);

`default_nettype wire
